// File: rtl/cfp_pkg.sv
// Shared types and constants for the coordinate frame parser.
`timescale 1ns / 1ps
`default_nettype none

package cfp_pkg;

   // Framing characters
   localparam logic [7:0] CH_OPEN  = 8'h5B;
   localparam logic [7:0] CH_CLOSE = 8'h5D;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_SPACE = 8'h20;
   // Upper nibble that marks a digit byte (0x30..0x3F)
   localparam logic [3:0] DIGIT_TAG = 4'h3;

   // Field widths
   localparam int POS_W   = 16;
   localparam int STEP_W  = POS_W + 1;
   localparam int SPEED_W = 25;
   localparam int HIST_DEPTH = 3;
   localparam int SUM_W   = STEP_W + 2;
   localparam int MAG_W   = SUM_W - 1;

   // Reset value of the jump limit
   localparam logic [POS_W-1:0] JUMP_LIMIT_RESET = 16'd20;

   // Divide by three: floor(n * RECIP3 / 2^RECIP_SHIFT) == floor(n / 3) for n < 2^19
   localparam int RECIP_SHIFT = 20;
   localparam int RECIP_W     = 19;
   localparam logic [RECIP_W-1:0] RECIP3 = 19'd349526;
   localparam int QUO_W = MAG_W + RECIP_W - RECIP_SHIFT;

   // Q8 fraction of r/3 for remainder r
   localparam logic [7:0] THIRD_Q8     = 8'd85;
   localparam logic [7:0] TWO_THIRD_Q8 = 8'd170;

   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_JUMP = 2'd1,
      STAT_BAD  = 2'd2
   } status_type;

   typedef logic signed [STEP_W-1:0] step_type;

   // Frame end event handed from the parser to the result stage
   typedef struct packed {
      logic       valid;
      status_type status;
   } evt_type;

endpackage

`default_nettype wire

// File: rtl/coordinate_frame_parser.sv
// Top level of the coordinate frame parser: handshakes, limit register, result register.
`timescale 1ns / 1ps
`default_nettype none

// Takes one frame byte per clock. The edge that takes a frame end beat sets an
// event register in the parser; the result register takes position, speeds
// and status from it once the result register is free (no result held or
// rsp_stall low). The speed divide by three is a reciprocal multiply between
// the step history and the result register. req_stall rises only while an
// event waits behind a stalled result; with rsp_stall low the block takes one
// byte every cycle. csr_ready is always high; write the jump limit only
// between frames.
module coordinate_frame_parser
   import cfp_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   // byte input
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [7:0]              req_rx_byte,
   input  wire logic                    req_frame_end,
   input  wire logic                    req_jump_check,
   // results
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [POS_W-1:0]             rsp_pos_x,
   output logic [POS_W-1:0]             rsp_pos_y,
   output logic signed [SPEED_W-1:0]    rsp_speed_x_q8,
   output logic signed [SPEED_W-1:0]    rsp_speed_y_q8,
   output logic [1:0]                   rsp_frame_status,
   // jump limit register
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [POS_W-1:0]        csr_jump_limit
);

   logic [POS_W-1:0] jump_limit_ff;
   logic             beat;
   logic             out_load;
   logic             evt_take;
   evt_type          evt;
   logic [POS_W-1:0] last_x, last_y;
   step_type         hist_x [HIST_DEPTH];
   step_type         hist_y [HIST_DEPTH];
   logic signed [SPEED_W-1:0] speed_x, speed_y;

   logic                      out_valid_ff, out_valid_in;
   logic [POS_W-1:0]          pos_x_ff, pos_y_ff;
   logic signed [SPEED_W-1:0] speed_x_ff, speed_y_ff;
   status_type                status_ff;

   // Limit register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         jump_limit_ff <= JUMP_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         jump_limit_ff <= csr_jump_limit;
      end
   end

   // Flow control: result register frees the event register
   assign out_load  = !out_valid_ff || !rsp_stall;
   assign evt_take  = evt.valid && out_load;
   assign req_stall = evt.valid && !out_load;
   assign beat      = req_valid && !req_stall;

   cfp_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .beat       (beat),
      .rx_byte    (req_rx_byte),
      .frame_end  (req_frame_end),
      .jump_check (req_jump_check),
      .jump_limit (jump_limit_ff),
      .evt_take   (evt_take),
      .evt        (evt),
      .last_x     (last_x),
      .last_y     (last_y),
      .hist_x     (hist_x),
      .hist_y     (hist_y)
   );

   cfp_speed u_speed_x (
      .hist  (hist_x),
      .speed (speed_x)
   );

   cfp_speed u_speed_y (
      .hist  (hist_y),
      .speed (speed_y)
   );

   // Result register
   assign out_valid_in = out_load ? evt.valid : out_valid_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (evt_take) begin
         pos_x_ff   <= last_x;
         pos_y_ff   <= last_y;
         speed_x_ff <= speed_x;
         speed_y_ff <= speed_y;
         status_ff  <= evt.status;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_pos_x        = pos_x_ff;
   assign rsp_pos_y        = pos_y_ff;
   assign rsp_speed_x_q8   = speed_x_ff;
   assign rsp_speed_y_q8   = speed_y_ff;
   assign rsp_frame_status = status_ff;

   // Input is only held off by an event stuck behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> evt.valid && out_valid_ff && rsp_stall)
      else $error("input stalled without a waiting event");

   // A moved event shows up as a result
   a_evt_to_rsp: assert property (@(posedge clock) disable iff (reset)
      evt_take |=> rsp_valid)
      else $error("event lost on its way to the result register");

endmodule

`default_nettype wire

// File: rtl/cfp_parser.sv
// Byte parser: field accumulators, frame check, jump test and step history.
`timescale 1ns / 1ps
`default_nettype none

module cfp_parser
   import cfp_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             beat,
   input  wire logic [7:0]       rx_byte,
   input  wire logic             frame_end,
   input  wire logic             jump_check,
   input  wire logic [POS_W-1:0] jump_limit,
   input  wire logic             evt_take,
   output evt_type               evt,
   output logic [POS_W-1:0]      last_x,
   output logic [POS_W-1:0]      last_y,
   output step_type              hist_x [HIST_DEPTH],
   output step_type              hist_y [HIST_DEPTH]
);

   logic [POS_W-1:0] x_accum_ff, x_accum_in;
   logic [POS_W-1:0] y_accum_ff, y_accum_in;
   logic             second_ff, second_in;
   logic             prev_comma_ff, prev_comma_in;
   logic             opened_ff, opened_in;
   logic             first_ff, first_in;
   logic [POS_W-1:0] last_x_ff, last_x_in;
   logic [POS_W-1:0] last_y_ff, last_y_in;
   step_type         hist_x_ff [HIST_DEPTH];
   step_type         hist_y_ff [HIST_DEPTH];
   logic             push;
   evt_type          evt_ff, evt_in;

   logic [POS_W-1:0]  digit_x, digit_y;
   logic              is_digit;
   step_type          step_x, step_y;
   logic [STEP_W-1:0] mag_x, mag_y;
   logic              far;

   // Decimal accumulate, wraps at 16 bits
   assign is_digit = (rx_byte[7:4] == DIGIT_TAG);
   assign digit_x  = {x_accum_ff[POS_W-4:0], 3'b000} + {x_accum_ff[POS_W-2:0], 1'b0}
                     + {{(POS_W-4){1'b0}}, rx_byte[3:0]};
   assign digit_y  = {y_accum_ff[POS_W-4:0], 3'b000} + {y_accum_ff[POS_W-2:0], 1'b0}
                     + {{(POS_W-4){1'b0}}, rx_byte[3:0]};

   // Step against the last accepted point and jump test
   assign step_x = step_type'({1'b0, x_accum_ff}) - step_type'({1'b0, last_x_ff});
   assign step_y = step_type'({1'b0, y_accum_ff}) - step_type'({1'b0, last_y_ff});
   assign mag_x  = step_x[STEP_W-1] ? (~step_x + 1'b1) : step_x;
   assign mag_y  = step_y[STEP_W-1] ? (~step_y + 1'b1) : step_y;
   assign far    = jump_check && ((mag_x > {1'b0, jump_limit}) || (mag_y > {1'b0, jump_limit}));

   // Next state per accepted beat
   always_comb begin
      x_accum_in    = x_accum_ff;
      y_accum_in    = y_accum_ff;
      second_in     = second_ff;
      prev_comma_in = prev_comma_ff;
      opened_in     = opened_ff;
      first_in      = first_ff;
      last_x_in     = last_x_ff;
      last_y_in     = last_y_ff;
      push          = 1'b0;
      evt_in        = evt_ff;
      if (evt_take) begin
         evt_in.valid = 1'b0;
      end
      if (beat) begin
         if (first_ff) begin
            x_accum_in    = '0;
            y_accum_in    = '0;
            second_in     = 1'b0;
            prev_comma_in = 1'b0;
            opened_in     = (rx_byte == CH_OPEN);
            first_in      = 1'b0;
            if (frame_end) begin
               // a single byte cannot both open and close
               opened_in     = 1'b0;
               first_in      = 1'b1;
               evt_in.valid  = 1'b1;
               evt_in.status = STAT_BAD;
            end
         end else if (!frame_end) begin
            if (is_digit) begin
               if (second_ff) begin
                  y_accum_in = digit_y;
               end else begin
                  x_accum_in = digit_x;
               end
            end else if (rx_byte == CH_SPACE && prev_comma_ff) begin
               second_in = 1'b1;
            end
            prev_comma_in = (rx_byte == CH_COMMA);
         end else begin
            first_in     = 1'b1;
            evt_in.valid = 1'b1;
            if (!(opened_ff && rx_byte == CH_CLOSE)) begin
               evt_in.status = STAT_BAD;
            end else if (far) begin
               evt_in.status = STAT_JUMP;
            end else begin
               evt_in.status = STAT_OK;
               push          = 1'b1;
               last_x_in     = x_accum_ff;
               last_y_in     = y_accum_ff;
            end
         end
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         x_accum_ff    <= '0;
         y_accum_ff    <= '0;
         second_ff     <= 1'b0;
         prev_comma_ff <= 1'b0;
         opened_ff     <= 1'b0;
         first_ff      <= 1'b1;
         last_x_ff     <= '0;
         last_y_ff     <= '0;
         evt_ff.valid  <= 1'b0;
         evt_ff.status <= STAT_OK;
         for (int i = 0; i < HIST_DEPTH; i++) begin
            hist_x_ff[i] <= '0;
            hist_y_ff[i] <= '0;
         end
      end else begin
         x_accum_ff    <= x_accum_in;
         y_accum_ff    <= y_accum_in;
         second_ff     <= second_in;
         prev_comma_ff <= prev_comma_in;
         opened_ff     <= opened_in;
         first_ff      <= first_in;
         last_x_ff     <= last_x_in;
         last_y_ff     <= last_y_in;
         evt_ff        <= evt_in;
         if (push) begin
            hist_x_ff[0] <= step_x;
            hist_y_ff[0] <= step_y;
            for (int i = 1; i < HIST_DEPTH; i++) begin
               hist_x_ff[i] <= hist_x_ff[i-1];
               hist_y_ff[i] <= hist_y_ff[i-1];
            end
         end
      end
   end

   assign evt    = evt_ff;
   assign last_x = last_x_ff;
   assign last_y = last_y_ff;
   assign hist_x = hist_x_ff;
   assign hist_y = hist_y_ff;

   // A frame end beat always rearms the first byte flag
   a_end_rearms: assert property (@(posedge clock) disable iff (reset)
      beat && frame_end |=> first_ff)
      else $error("frame end did not rearm first byte");

   // Position only moves on an accepted frame
   a_pos_hold: assert property (@(posedge clock) disable iff (reset)
      evt_ff.valid && evt_ff.status != STAT_OK |-> $stable(last_x_ff) && $stable(last_y_ff))
      else $error("position moved on a refused frame");

   // Every frame end beat raises an event
   a_evt_raised: assert property (@(posedge clock) disable iff (reset)
      beat && frame_end |=> evt_ff.valid)
      else $error("frame end lost its event");

endmodule

`default_nettype wire

// File: rtl/cfp_speed.sv
// Speed of one axis: sum of three steps times 256 over 3, truncated toward zero.
`timescale 1ns / 1ps
`default_nettype none

module cfp_speed
   import cfp_pkg::*;
(
   input  step_type                   hist [HIST_DEPTH],
   output logic signed [SPEED_W-1:0]  speed
);

   logic signed [SUM_W-1:0]        sum;
   logic                           neg;
   logic [SUM_W-1:0]               mag_full;
   logic [MAG_W-1:0]               mag;
   logic [MAG_W+RECIP_W-1:0]       prod;
   logic [QUO_W-1:0]               quo;
   logic [MAG_W-1:0]               three_q;
   logic [1:0]                     rem;
   logic [7:0]                     frac;
   logic [SPEED_W-1:0]             q_mag;

   // Sum of the history, sign and magnitude
   always_comb begin
      sum = '0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
         sum = sum + SUM_W'(hist[i]);
      end
   end
   assign neg      = sum[SUM_W-1];
   assign mag_full = neg ? (~sum + 1'b1) : sum;
   assign mag      = mag_full[MAG_W-1:0];

   // Magnitude over 3 by reciprocal, then the remainder
   assign prod    = {{RECIP_W{1'b0}}, mag} * {{MAG_W{1'b0}}, RECIP3};
   assign quo     = prod[MAG_W+RECIP_W-1:RECIP_SHIFT];
   assign three_q = MAG_W'({quo, 1'b0}) + MAG_W'(quo);
   assign rem     = 2'(mag - three_q);

   // Q8 part of the remainder over 3
   always_comb begin
      case (rem)
         2'd1:    frac = THIRD_Q8;
         2'd2:    frac = TWO_THIRD_Q8;
         default: frac = 8'd0;
      endcase
   end

   assign q_mag = SPEED_W'({quo, frac});
   assign speed = neg ? signed'(~q_mag + 1'b1) : signed'(q_mag);

endmodule

`default_nettype wire
